/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: property failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

/* rtl/core/stm_pkg.sv */
// ----------------------------------------------------------------------------
// stm_pkg
// Shared widths, codes and types of the stepper move step counter.
// ----------------------------------------------------------------------------
`default_nettype none

package stm_pkg;

  localparam int unsigned CfgW     = 16;
  localparam int unsigned DistW    = 24;
  localparam int unsigned FreqW    = 24;
  localparam int unsigned PosW     = 16;
  localparam int unsigned DividendW = 32;
  localparam int unsigned DivisorW = 22;   // holds 60 * units_per_rev
  localparam int unsigned StepCntW = 5;    // counts DividendW iterations
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned SecPerMin = 60;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_EVENT = 2'd2
  } action_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_UNITS_PER_REV = 3'd0,
    REG_STEPS_PER_REV = 3'd1,
    REG_UNITS_PER_MIN = 3'd2,
    REG_DIST_MODE     = 3'd3,
    REG_DIRECTION     = 3'd4,
    REG_HALF_PERIOD   = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LAUNCH_FREQ,
    ST_WAIT_FREQ,
    ST_LAUNCH_REVS,
    ST_WAIT_REVS,
    ST_LAUNCH_TGT,
    ST_WAIT_TGT,
    ST_APPLY,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic                 start;
    logic [DividendW-1:0] dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

/* rtl/core/stm_divider.sv */
// ----------------------------------------------------------------------------
// stm_divider
// Restoring divider, one quotient bit per cycle, shared by all start math.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stm_divider
  import stm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire div_req_t             req_i,
  output div_sts_t                  sts_o,
  output logic     [DividendW-1:0]  quo_o,
  output logic     [DivisorW-1:0]   rem_o
);

  localparam logic [StepCntW-1:0] LastStep = StepCntW'(DividendW - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [StepCntW-1:0]  cnt_q, cnt_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dsr_q, dsr_d;
  logic [DivisorW:0]    shifted;
  logic [DivisorW:0]    trial;
  logic                 fits;

  // Bring down the next dividend bit and try a subtract.
  assign shifted = {rem_q, quo_q[DividendW-1]};
  assign fits    = shifted >= {1'b0, dsr_q};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[DividendW-2:0], fits};
      rem_d = fits ? trial[DivisorW-1:0] : shifted[DivisorW-1:0];
      cnt_d = cnt_q + StepCntW'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign sts_o = '{busy: busy_q, done: done_q};
  assign quo_o = quo_q;
  assign rem_o = rem_q;

  `ASSERT_NEVER(a_no_restart, req_i.start && busy_q)
  `ASSERT_AT(a_done_after_busy, done_q |-> (!busy_q && $past(busy_q)))

endmodule

`default_nettype wire

/* rtl/core/stepper_move_step_counter.sv */
// Stop, timer event or unknown action: the result is applied in ST_APPLY and sent
// from ST_REPLY. A start sets the step frequency through the shared 32-step divider;
// a distance start makes three passes (frequency, revolutions, target).
// One item is in flight at a time; the next word is taken once the result is in
// the output register. Reset (rst_ni low, asynchronous) loads the register
// defaults, clears all motion state and sets the step frequency to 1.
// ----------------------------------------------------------------------------
// stepper_move_step_counter
// Stepper move controller: step frequency, distance split and step counting.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stepper_move_step_counter
  import stm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  // command channel
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [DistW-1:0]    move_distance_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     moving_o,
  output logic [FreqW-1:0]         step_freq_o,
  output logic [DistW-1:0]         revs_left_o,
  output logic [PosW-1:0]          step_in_rev_o,
  output logic                     step_counted_o,
  output logic                     move_done_o,
  output logic                     dir_out_o
);

  // --------------------------------------------------------------------------
  // Configuration registers; writes are always taken, unknown indexes drop.
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] upr_q, spr_q, upm_q;
  logic            dmode_q, dir_q, hp_q;
  logic            cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upr_q   <= CfgW'(1);
      spr_q   <= CfgW'(200);
      upm_q   <= '0;
      dmode_q <= 1'b0;
      dir_q   <= 1'b0;
      hp_q    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr_i)
        REG_UNITS_PER_REV: upr_q   <= cfg_data_i;
        REG_STEPS_PER_REV: spr_q   <= cfg_data_i;
        REG_UNITS_PER_MIN: upm_q   <= cfg_data_i;
        REG_DIST_MODE:     dmode_q <= cfg_data_i[0];
        REG_DIRECTION:     dir_q   <= cfg_data_i[0];
        REG_HALF_PERIOD:   hp_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Zero units per revolution divides as one.
  logic [CfgW-1:0]     div_units;
  logic [DivisorW-1:0] div_freq;

  assign div_units = (upr_q == '0) ? CfgW'(1) : upr_q;
  // Fold the per-minute to per-second step into one divisor: x/60/d == x/(60*d).
  assign div_freq  = DivisorW'(div_units) * DivisorW'(SecPerMin);

  // --------------------------------------------------------------------------
  // Sequencer and motion state
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [1:0]        action_q;
  logic [DistW-1:0]  dist_q;
  logic [CfgW-1:0]   rem_q;
  logic [DistW-1:0]  rev_q;
  logic [PosW-1:0]   pos_q;
  logic [PosW-1:0]   tgt_q;
  logic              phase_q, run_q, dact_q;
  logic [FreqW-1:0]  freq_q;
  logic              counted_q, done_q;
  logic              out_valid_q;
  logic              in_accept, out_free;

  div_req_t               div_req;
  div_sts_t               div_sts;
  logic [DividendW-1:0]   div_quo;
  logic [DivisorW-1:0]    div_rem;
  logic [CfgW-1:0]        mul_a;
  logic [DividendW-1:0]   mul_p;

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  // Shared 16x16 multiplier, feeds the divider's operand register directly.
  assign mul_a = (state_q == ST_LAUNCH_TGT) ? rem_q : upm_q;
  assign mul_p = DividendW'(mul_a) * DividendW'(spr_q);

  stm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .sts_o  (div_sts),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (action_i == ACT_START) ? ST_LAUNCH_FREQ : ST_APPLY;
        end
      end
      ST_LAUNCH_FREQ: state_d = ST_WAIT_FREQ;
      ST_WAIT_FREQ: begin
        if (div_sts.done) begin
          state_d = dmode_q ? ST_LAUNCH_REVS : ST_REPLY;
        end
      end
      ST_LAUNCH_REVS: state_d = ST_WAIT_REVS;
      ST_WAIT_REVS: begin
        if (div_sts.done) begin
          state_d = ST_LAUNCH_TGT;
        end
      end
      ST_LAUNCH_TGT: state_d = ST_WAIT_TGT;
      ST_WAIT_TGT: begin
        if (div_sts.done) begin
          state_d = ST_REPLY;
        end
      end
      ST_APPLY: state_d = ST_REPLY;
      ST_REPLY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider launches
  always_comb begin
    in_ready_o       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mul_p;
    div_req.divisor  = div_freq;
    unique case (state_q)
      ST_IDLE:        in_ready_o = 1'b1;
      ST_LAUNCH_FREQ: div_req.start = 1'b1;
      ST_LAUNCH_REVS: begin
        div_req.start    = 1'b1;
        div_req.dividend = DividendW'(dist_q);
        div_req.divisor  = DivisorW'(div_units);
      end
      ST_LAUNCH_TGT: begin
        div_req.start   = 1'b1;
        div_req.divisor = DivisorW'(div_units);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the command word while it is worked on.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= action_i;
      dist_q   <= move_distance_i;
    end
  end

  // Timer event step math: advance, wrap once per revolution, check target.
  logic [PosW-1:0]  pos_inc, pos_new;
  logic [DistW-1:0] rev_new;
  logic             wrap, wrap_zero, hit, take;

  assign pos_inc   = pos_q + PosW'(1);
  assign wrap      = (pos_inc == spr_q);
  assign pos_new   = wrap ? '0 : pos_inc;
  assign wrap_zero = wrap && (rev_q == '0);
  assign rev_new   = (wrap && (rev_q != '0)) ? rev_q - DistW'(1) : rev_q;
  assign hit       = wrap_zero || ((rev_new == '0) && (pos_new == tgt_q));
  // Half-period mode counts only every second event.
  assign take      = run_q && dact_q && (!hp_q || phase_q);

  // Saturated, at-least-one frequency from the first quotient.
  logic [FreqW-1:0] freq_new;
  logic [PosW-1:0]  tgt_quo;

  always_comb begin
    if (div_quo[DividendW-1:FreqW] != '0) begin
      freq_new = '1;
    end else if (div_quo[FreqW-1:0] == '0) begin
      freq_new = FreqW'(1);
    end else begin
      freq_new = div_quo[FreqW-1:0];
    end
  end

  assign tgt_quo = div_quo[PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q     <= '0;
      pos_q     <= '0;
      tgt_q     <= '0;
      phase_q   <= 1'b0;
      run_q     <= 1'b0;
      dact_q    <= 1'b0;
      freq_q    <= FreqW'(1);
      counted_q <= 1'b0;
      done_q    <= 1'b0;
      rem_q     <= '0;
    end else begin
      case (state_q)
        ST_LAUNCH_FREQ: begin
          counted_q <= 1'b0;
          done_q    <= 1'b0;
        end
        ST_WAIT_FREQ: begin
          if (div_sts.done) begin
            freq_q <= freq_new;
            if (!dmode_q) begin
              dact_q <= 1'b0;
              run_q  <= 1'b1;
            end
          end
        end
        ST_WAIT_REVS: begin
          if (div_sts.done) begin
            rev_q <= div_quo[DistW-1:0];
            rem_q <= div_rem[CfgW-1:0];
          end
        end
        ST_WAIT_TGT: begin
          if (div_sts.done) begin
            // A zero move still takes one step.
            tgt_q   <= ((rev_q == '0) && (tgt_quo == '0)) ? PosW'(1) : tgt_quo;
            pos_q   <= '0;
            phase_q <= 1'b0;
            dact_q  <= 1'b1;
            run_q   <= 1'b1;
          end
        end
        ST_APPLY: begin
          counted_q <= 1'b0;
          done_q    <= 1'b0;
          if (action_q == ACT_STOP) begin
            run_q <= 1'b0;
          end else if (action_q == ACT_EVENT && run_q && dact_q) begin
            if (hp_q) begin
              phase_q <= !phase_q;
            end
            if (take) begin
              counted_q <= 1'b1;
              pos_q     <= pos_new;
              rev_q     <= rev_new;
              if (hit) begin
                run_q  <= 1'b0;
                done_q <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register: load the word once the slot is free.
  // --------------------------------------------------------------------------
  logic load_out;

  assign load_out = (state_q == ST_REPLY) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      moving_o       <= run_q;
      step_freq_o    <= freq_q;
      revs_left_o    <= rev_q;
      step_in_rev_o  <= pos_q;
      step_counted_o <= counted_q;
      move_done_o    <= done_q;
      dir_out_o      <= dir_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_AT(a_freq_nonzero, freq_q != '0)
  `ASSERT_AT(a_done_stops, (out_valid_o && move_done_o) |-> (!moving_o && step_counted_o))
  `ASSERT_AT(a_accept_leaves_idle, in_accept |=> (state_q != ST_IDLE))
  `ASSERT_NEVER(a_launch_while_busy, div_req.start && div_sts.busy)

endmodule

`default_nettype wire
